// ===== src/tps_pkg.sv =====
`default_nettype none

package tps_pkg;

   // Pattern geometry
   localparam int PatternLen = 6;
   localparam int IdxW       = $clog2(PatternLen);
   localparam int PresetLen  = 6;
   localparam int NumVoices  = 6;
   localparam int NumDiv     = NumVoices - 1;
   localparam int NumPresets = 4;
   localparam int NumPatCmds = NumPresets + 1;

   // Field widths
   localparam int FuncW   = 2;
   localparam int ByteW   = 8;
   localparam int TicksW  = 8;
   localparam int PresetW = 18;
   localparam int DivW    = 5;
   localparam int ChoiceW = 3;
   localparam int CsrIdxW = 3;
   localparam int CsrW    = 18;

   // Event kinds
   localparam logic [FuncW-1:0] FuncCmd  = 2'd0;
   localparam logic [FuncW-1:0] FuncTone = 2'd1;
   localparam logic [FuncW-1:0] FuncStep = 2'd2;

   // Register indexes
   localparam logic [CsrIdxW-1:0] RegStepTicks = 3'd0;
   localparam logic [CsrIdxW-1:0] RegPreset0   = 3'd1;
   localparam logic [CsrIdxW-1:0] RegPreset3   = 3'd4;

   // Register reset values
   localparam logic [TicksW-1:0]  StepTicksRst = 8'd19;
   localparam logic [PresetW-1:0] PresetRst [NumPresets] =
      '{18'd219345, 18'd214361, 18'd42705, 18'd203889};

   // Command bytes
   localparam logic [ByteW-1:0] VoiceOnCode  [NumVoices] =
      '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36};
   localparam logic [ByteW-1:0] VoiceOffCode [NumVoices] =
      '{8'h77, 8'h73, 8'h78, 8'h72, 8'h66, 8'h76};
   localparam logic [ByteW-1:0] PatCode [NumPatCmds] =
      '{8'h37, 8'h38, 8'h39, 8'h30, 8'h69};
   localparam logic [ByteW-1:0] CmdStop    = 8'h6f;
   localparam logic [ByteW-1:0] CmdRecord  = 8'h70;
   localparam logic [ByteW-1:0] DigitBias  = 8'd48;

   localparam logic [ChoiceW-1:0] ChoiceCustom = 3'd4;

   typedef struct packed {
      logic [TicksW-1:0]                     step_ticks;
      logic [NumPresets-1:0][PresetW-1:0]    preset;
   } cfg_type;

   typedef struct packed {
      logic                 tone_level;
      logic [NumVoices-1:0] voice_enables;
      logic                 stepping;
      logic                 recording;
   } rsp_type;

   // Entry k of a preset word; entries past the stored ones read as zero
   function automatic logic [ByteW-1:0] preset_entry(input logic [PresetW-1:0] word,
                                                     input logic [IdxW-1:0] k);
      logic [ByteW-1:0] res;
      res = '0;
      for (int i = 0; i < PresetLen; i++) begin
         if (int'(k) == i) begin
            res = {5'b0, word[3*i +: 3]};
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== src/tps_req_if.sv =====
`default_nettype none

interface tps_req_if
   import tps_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [FuncW-1:0] func;
   logic [ByteW-1:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/tps_rsp_if.sv =====
`default_nettype none

interface tps_rsp_if
   import tps_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 tone_level;
   logic [NumVoices-1:0] voice_enables;
   logic                 stepping;
   logic                 recording;

   modport source (output valid, output tone_level, output voice_enables,
                   output stepping, output recording, input ready);
   modport sink   (input valid, input tone_level, input voice_enables,
                   input stepping, input recording, output ready);
endinterface

`default_nettype wire

// ===== src/tps_csr.sv =====
`default_nettype none

module tps_csr
   import tps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [CsrW-1:0]    csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         if (csr_index == RegStepTicks) begin
            cfg_in.step_ticks = csr_wdata[TicksW-1:0];
         end else if (csr_index >= RegPreset0 && csr_index <= RegPreset3) begin
            cfg_in.preset[2'(csr_index - RegPreset0)] = csr_wdata[PresetW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_ticks <= StepTicksRst;
         for (int i = 0; i < NumPresets; i++) begin
            cfg_ff.preset[i] <= PresetRst[i];
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/tps_core.sv =====
`default_nettype none

module tps_core
   import tps_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic [FuncW-1:0] func,
   input  wire logic [ByteW-1:0] rx_byte,
   input  wire cfg_type          cfg,
   output rsp_type               result
);

   logic                 pin_ff, pin_in;
   logic [NumVoices-1:0] voice_ff, voice_in;
   logic [DivW-1:0]      div_cnt_ff [NumDiv];
   logic [DivW-1:0]      div_cnt_in [NumDiv];
   logic [TicksW-1:0]    tick_cnt_ff, tick_cnt_in;
   logic [IdxW-1:0]      pat_idx_ff, pat_idx_in;
   logic [ChoiceW-1:0]   choice_ff, choice_in;
   logic                 step_ff, step_in;
   logic                 rec_ff, rec_in;
   logic [IdxW-1:0]      rec_pos_ff, rec_pos_in;
   logic [ByteW-1:0]     custom_ff [PatternLen];
   logic [ByteW-1:0]     custom_in [PatternLen];

   logic [DivW:0]        cnt_inc [NumDiv];
   logic [NumDiv-1:0]    cnt_live;
   logic [NumDiv-1:0]    cnt_hit;
   logic                 tone_flip;
   logic [TicksW-1:0]    tick_nxt;
   logic [ByteW-1:0]     entry;

   // Divider counters: advance only below the divisor, wrap on reaching it
   always_comb begin
      for (int v = 0; v < NumDiv; v++) begin
         cnt_inc[v]  = {1'b0, div_cnt_ff[v]} + (DivW+1)'(1);
         cnt_live[v] = voice_ff[v+1] && ({1'b0, div_cnt_ff[v]} < ((DivW+1)'(2) << v));
         cnt_hit[v]  = cnt_live[v] && (cnt_inc[v] == ((DivW+1)'(2) << v));
      end
      tone_flip = voice_ff[0] ^ (^cnt_hit);
   end

   assign tick_nxt = tick_cnt_ff + TicksW'(1);
   assign entry    = (choice_ff >= ChoiceCustom) ? custom_ff[pat_idx_ff]
                                                 : preset_entry(cfg.preset[choice_ff[1:0]],
                                                                pat_idx_ff);

   always_comb begin
      pin_in      = pin_ff;
      voice_in    = voice_ff;
      div_cnt_in  = div_cnt_ff;
      tick_cnt_in = tick_cnt_ff;
      pat_idx_in  = pat_idx_ff;
      choice_in   = choice_ff;
      step_in     = step_ff;
      rec_in      = rec_ff;
      rec_pos_in  = rec_pos_ff;
      custom_in   = custom_ff;
      case (func)
         FuncCmd: begin
            if (rec_ff) begin
               // store the byte as a voice number, never decode it
               custom_in[rec_pos_ff] = rx_byte - DigitBias;
               if (rec_pos_ff == IdxW'(PatternLen - 1)) begin
                  rec_pos_in = '0;
                  rec_in     = 1'b0;
               end else begin
                  rec_pos_in = rec_pos_ff + IdxW'(1);
               end
            end else begin
               for (int v = 0; v < NumVoices; v++) begin
                  if (rx_byte == VoiceOnCode[v]) begin
                     voice_in[v] = 1'b1;
                  end
                  if (rx_byte == VoiceOffCode[v]) begin
                     voice_in[v] = 1'b0;
                     pin_in      = 1'b0;
                  end
               end
               for (int v = 0; v < NumPatCmds; v++) begin
                  if (rx_byte == PatCode[v]) begin
                     step_in   = 1'b1;
                     choice_in = ChoiceW'(v);
                  end
               end
               if (rx_byte == CmdStop) begin
                  step_in  = 1'b0;
                  voice_in = '0;
                  pin_in   = 1'b0;
               end
               if (rx_byte == CmdRecord) begin
                  rec_in = 1'b1;
               end
            end
         end
         FuncTone: begin
            pin_in = pin_ff ^ tone_flip;
            for (int v = 0; v < NumDiv; v++) begin
               if (cnt_hit[v]) begin
                  div_cnt_in[v] = '0;
               end else if (cnt_live[v]) begin
                  div_cnt_in[v] = cnt_inc[v][DivW-1:0];
               end
            end
         end
         FuncStep: begin
            if (step_ff) begin
               if (tick_nxt >= cfg.step_ticks) begin
                  tick_cnt_in = '0;
                  if (entry >= ByteW'(1) && entry <= ByteW'(NumVoices)) begin
                     voice_in = NumVoices'(1) << (entry[2:0] - 3'd1);
                  end
                  if (pat_idx_ff == IdxW'(PatternLen - 1)) begin
                     pat_idx_in = '0;
                  end else begin
                     pat_idx_in = pat_idx_ff + IdxW'(1);
                  end
               end else begin
                  tick_cnt_in = tick_nxt;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff      <= 1'b0;
         voice_ff    <= '0;
         tick_cnt_ff <= '0;
         pat_idx_ff  <= '0;
         choice_ff   <= '0;
         step_ff     <= 1'b0;
         rec_ff      <= 1'b0;
         rec_pos_ff  <= '0;
         for (int v = 0; v < NumDiv; v++) begin
            div_cnt_ff[v] <= '0;
         end
         for (int k = 0; k < PatternLen; k++) begin
            custom_ff[k] <= '0;
         end
      end else if (advance) begin
         pin_ff      <= pin_in;
         voice_ff    <= voice_in;
         div_cnt_ff  <= div_cnt_in;
         tick_cnt_ff <= tick_cnt_in;
         pat_idx_ff  <= pat_idx_in;
         choice_ff   <= choice_in;
         step_ff     <= step_in;
         rec_ff      <= rec_in;
         rec_pos_ff  <= rec_pos_in;
         custom_ff   <= custom_in;
      end
   end

   assign result.tone_level    = pin_in;
   assign result.voice_enables = voice_in;
   assign result.stepping      = step_in;
   assign result.recording     = rec_in;

endmodule

`default_nettype wire

// ===== src/tone_pattern_sequencer_unit.sv =====
// Tone pattern sequencer.
// req_ch carries one event per transaction: func 0 is a command byte in
// rx_byte, func 1 a tone tick, func 2 a step tick; func 3 changes nothing.
// rsp_ch returns exactly one transaction per event: the pin level, voice
// enables, stepping and recording flags as they stand after that event.
// The csr_ port writes step_ticks (index 0) and the four preset patterns
// (indexes 1 to 4), one per write; write it only while no event is in flight.
// An event passes an input register, then combinational decode and state
// update that writes the output register, which raises rsp_ch.valid.
// One event per cycle is sustained while rsp_ch does not stall.
// When rsp_ch stalls, the result holds in the output register and one more
// event waits in the input register; req_ch.ready then drops.
// Reset is synchronous: it clears all voice, counter, stepper and custom
// pattern state, empties both registers and loads the register defaults.
// No clearing pass follows reset; events are taken on the next cycle.
`default_nettype none

module tone_pattern_sequencer_unit
   import tps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   tps_req_if.sink                 req_ch,
   tps_rsp_if.source               rsp_ch,
   input  wire logic               csr_we,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [CsrW-1:0]    csr_wdata
);

   cfg_type          cfg;
   rsp_type          result;

   logic             in_vld_ff;
   logic [FuncW-1:0] in_func_ff;
   logic [ByteW-1:0] in_byte_ff;
   logic             out_vld_ff;
   rsp_type          out_data_ff;
   logic             advance;
   logic             take;

   assign advance      = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   tps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tps_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .func    (in_func_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (take) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers: load on transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         in_func_ff <= req_ch.func;
         in_byte_ff <= req_ch.rx_byte;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.tone_level    = out_data_ff.tone_level;
   assign rsp_ch.voice_enables = out_data_ff.voice_enables;
   assign rsp_ch.stepping      = out_data_ff.stepping;
   assign rsp_ch.recording     = out_data_ff.recording;

endmodule

`default_nettype wire

// ===== bench/tone_pattern_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps

module tone_pattern_sequencer_unit_tb;
   import tps_pkg::*;

   localparam logic [FuncW-1:0] FuncNone = 2'd3;  // undefined event kind
   localparam int DrainCycles   = 4;
   localparam int RspHoldCycles = 48;
   localparam int StallLimit    = 1000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0] csr_wdata;

   tps_req_if req_if ();
   tps_rsp_if rsp_if ();

   tone_pattern_sequencer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Sequencer state as the block should hold it
   cfg_type active_cfg;
   logic pin_q;
   logic [NumVoices-1:0] voices_q;
   logic [5:0] divider_q [NumDiv];
   logic [TicksW-1:0] ticks_q;
   logic [IdxW-1:0] index_q;
   logic [ChoiceW-1:0] choice_q;
   logic stepping_q;
   logic recording_q;
   logic [IdxW-1:0] rec_pos_q;
   logic [ByteW-1:0] custom_q [PatternLen];

   rsp_type outputs_due [$];
   int events_sent;
   int mismatches;
   bit req_gaps_on;
   bit rsp_stalls_on;
   bit hold_rsp;

   always #5 clock = ~clock;

   function automatic rsp_type advance_sequencer(input logic [FuncW-1:0] f,
                                                 input logic [ByteW-1:0] b);
      rsp_type r;
      logic [ByteW-1:0] entry;
      logic [5:0] div;
      case (f)
         FuncCmd: begin
            if (recording_q) begin
               custom_q[rec_pos_q] = b - DigitBias;
               rec_pos_q = rec_pos_q + 1'b1;
               if (rec_pos_q >= IdxW'(PatternLen)) begin
                  rec_pos_q = '0;
                  recording_q = 1'b0;
               end
            end else begin
               for (int v = 0; v < NumVoices; v++) begin
                  if (b == VoiceOnCode[v]) voices_q[v] = 1'b1;
                  if (b == VoiceOffCode[v]) begin
                     voices_q[v] = 1'b0;
                     pin_q = 1'b0;
                  end
               end
               for (int v = 0; v < NumPatCmds; v++) begin
                  if (b == PatCode[v]) begin
                     stepping_q = 1'b1;
                     choice_q = ChoiceW'(v);
                  end
               end
               if (b == CmdStop) begin
                  stepping_q = 1'b0;
                  voices_q = '0;
                  pin_q = 1'b0;
               end
               if (b == CmdRecord) recording_q = 1'b1;
            end
         end
         FuncTone: begin
            if (voices_q[0]) pin_q = ~pin_q;
            for (int v = 1; v < NumVoices; v++) begin
               div = 6'd1 << v;
               if (voices_q[v] && divider_q[v-1] < div) begin
                  divider_q[v-1] = divider_q[v-1] + 1'b1;
                  if (divider_q[v-1] == div) begin
                     divider_q[v-1] = '0;
                     pin_q = ~pin_q;
                  end
               end
            end
         end
         FuncStep: begin
            if (stepping_q) begin
               ticks_q = ticks_q + 1'b1;
               if (ticks_q >= active_cfg.step_ticks) begin
                  ticks_q = '0;
                  if (choice_q >= ChoiceCustom) entry = custom_q[index_q];
                  else entry = ByteW'(active_cfg.preset[choice_q][3*index_q +: 3]);
                  if (entry >= 1 && entry <= NumVoices)
                     voices_q = NumVoices'(1) << (entry - 1);
                  if (index_q == IdxW'(PatternLen - 1)) index_q = '0;
                  else index_q = index_q + 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.tone_level    = pin_q;
      r.voice_enables = voices_q;
      r.stepping      = stepping_q;
      r.recording     = recording_q;
      return r;
   endfunction

   function automatic cfg_type make_cfg(input logic [TicksW-1:0] ticks, input bit rand_presets);
      cfg_type c;
      c.step_ticks = ticks;
      for (int i = 0; i < NumPresets; i++)
         c.preset[i] = rand_presets ? PresetW'($urandom) : PresetRst[i];
      return c;
   endfunction

   // Block must be idle; all five registers go out in turn, one write each
   task automatic write_config(input cfg_type c);
      for (int i = 0; i <= NumPresets; i++) begin
         csr_we    <= 1'b1;
         csr_index <= (i == 0) ? RegStepTicks : RegPreset0 + CsrIdxW'(i - 1);
         csr_wdata <= (i == 0) ? CsrW'(c.step_ticks) : CsrW'(c.preset[i-1]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      active_cfg = c;
   endtask

   task automatic send_event(input logic [FuncW-1:0] f, input logic [ByteW-1:0] b);
      int gap;
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.func    <= f;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      outputs_due.push_back(advance_sequencer(f, b));
      events_sent++;
   endtask

   task automatic send_random_event();
      int r;
      int n;
      int k;
      logic [ByteW-1:0] b;
      r = $urandom_range(0, 99);
      if (r < 34) begin
         send_event(FuncTone, ByteW'($urandom));
      end else if (r < 58) begin
         send_event(FuncStep, ByteW'($urandom));
      end else if (r < 62) begin
         send_event(FuncNone, ByteW'($urandom));
      end else if (r < 66) begin
         send_event(FuncCmd, ByteW'($urandom));
      end else if (r < 71) begin
         // record a custom pattern, mostly digits, sometimes cut short
         send_event(FuncCmd, CmdRecord);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PatternLen - 1) : PatternLen;
         for (int i = 0; i < n; i++) begin
            b = ($urandom_range(0, 4) == 0) ? ByteW'($urandom)
                                            : DigitBias + ByteW'($urandom_range(0, 9));
            send_event(FuncCmd, b);
         end
      end else begin
         k = $urandom_range(0, 19);
         if (k < 9) send_event(FuncCmd, VoiceOnCode[$urandom_range(0, NumVoices - 1)]);
         else if (k < 13) send_event(FuncCmd, VoiceOffCode[$urandom_range(0, NumVoices - 1)]);
         else if (k < 19) send_event(FuncCmd, PatCode[$urandom_range(0, NumPatCmds - 1)]);
         else send_event(FuncCmd, CmdStop);
      end
   endtask

   task automatic run_traffic(input int count);
      int target;
      target = events_sent + count;
      while (events_sent < target) send_random_event();
   endtask

   task automatic drain_outputs();
      req_if.valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic test_directed();
      write_config(make_cfg(8'd1, 1'b0));
      for (int v = 0; v < NumVoices; v++) send_event(FuncCmd, VoiceOnCode[v]);
      send_event(FuncTone, 8'hff);
      send_event(FuncTone, 8'h00);
      for (int v = 0; v < NumVoices; v++) send_event(FuncCmd, VoiceOffCode[v]);
      // custom pattern with both byte extremes, then step through it
      send_event(FuncCmd, CmdRecord);
      send_event(FuncCmd, DigitBias + 8'd1);
      send_event(FuncCmd, 8'h00);
      send_event(FuncCmd, 8'hff);
      send_event(FuncCmd, DigitBias + 8'd6);
      send_event(FuncCmd, DigitBias + 8'd3);
      send_event(FuncCmd, DigitBias + 8'd2);
      for (int v = 0; v < NumPatCmds; v++) send_event(FuncCmd, PatCode[v]);
      send_event(FuncStep, 8'h00);
      send_event(FuncStep, 8'hff);
      send_event(FuncCmd, CmdStop);
      send_event(FuncStep, 8'h00);
      send_event(FuncNone, 8'hff);
      send_event(FuncCmd, 8'h00);
      drain_outputs();
   endtask

   task automatic test_fast_stepping();
      write_config(make_cfg(8'd1, 1'b1));
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      run_traffic(300);
      drain_outputs();
   endtask

   task automatic test_slow_stepping();
      cfg_type c;
      c = make_cfg(8'd255, 1'b1);
      c.preset[0] = '0;
      c.preset[1] = '1;
      write_config(c);
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b0;
      run_traffic(250);
      drain_outputs();
   endtask

   task automatic test_default_timing();
      write_config(make_cfg(StepTicksRst, 1'b0));
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b1;
      run_traffic(250);
      drain_outputs();
   endtask

   task automatic test_backpressure();
      write_config(make_cfg(8'd2, 1'b1));
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      hold_rsp      = 1'b1;
      run_traffic(30);
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      run_traffic(70);
      drain_outputs();
   endtask

   task automatic test_steady_stream();
      write_config(make_cfg(TicksW'($urandom_range(1, 6)), 1'b1));
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      run_traffic(500);
      drain_outputs();
   endtask

   task automatic check_output();
      rsp_type want;
      if (outputs_due.size() == 0) begin
         $display("%0t: unexpected transaction: actual %b/%b/%b/%b", $time,
                  rsp_if.tone_level, rsp_if.voice_enables, rsp_if.stepping,
                  rsp_if.recording);
         mismatches++;
      end else begin
         want = outputs_due.pop_front();
         if (rsp_if.tone_level !== want.tone_level) begin
            $display("%0t: tone_level expected %0b actual %0b", $time,
                     want.tone_level, rsp_if.tone_level);
            mismatches++;
         end
         if (rsp_if.voice_enables !== want.voice_enables) begin
            $display("%0t: voice_enables expected %b actual %b", $time,
                     want.voice_enables, rsp_if.voice_enables);
            mismatches++;
         end
         if (rsp_if.stepping !== want.stepping) begin
            $display("%0t: stepping expected %0b actual %0b", $time,
                     want.stepping, rsp_if.stepping);
            mismatches++;
         end
         if (rsp_if.recording !== want.recording) begin
            $display("%0t: recording expected %0b actual %0b", $time,
                     want.recording, rsp_if.recording);
            mismatches++;
         end
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      int hold_count;
      stall_left = 0;
      hold_count = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) check_output();
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            hold_count++;
            if (hold_count >= RspHoldCycles) begin
               hold_rsp   = 1'b0;
               hold_count = 0;
            end
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog: give up after a long run of cycles with no transaction
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = RegStepTicks;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.func    = FuncCmd;
      req_if.rx_byte = '0;
      events_sent    = 0;
      mismatches     = 0;
      req_gaps_on    = 1'b0;
      rsp_stalls_on  = 1'b0;
      hold_rsp       = 1'b0;
      active_cfg     = make_cfg(StepTicksRst, 1'b0);
      pin_q          = 1'b0;
      voices_q       = '0;
      ticks_q        = '0;
      index_q        = '0;
      choice_q       = '0;
      stepping_q     = 1'b0;
      recording_q    = 1'b0;
      rec_pos_q      = '0;
      for (int i = 0; i < NumDiv; i++) divider_q[i] = '0;
      for (int i = 0; i < PatternLen; i++) custom_q[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fast_stepping();
      test_slow_stepping();
      test_default_timing();
      test_backpressure();
      test_steady_stream();

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
